/* hdl/spq_pkg.sv */
`timescale 1ns / 1ps

package spq_pkg;

	// cells per group of the registered selection tree
	localparam int GROUP = 32;
	localparam int LOC_W = $clog2(GROUP);

	typedef enum logic [1:0] {
		REQ_INSERT      = 2'd0,
		REQ_REMOVE_HEAD = 2'd1,
		REQ_REMOVE_AT   = 2'd2,
		REQ_QUERY       = 2'd3
	} req_e_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_e_t;

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_GATHER = 3'b010,
		S_FINISH = 3'b100
	} state_t;

	typedef struct packed {
		logic [15:0] id;
		logic [7:0]  pri;
	} entry_t;

	typedef struct packed {
		req_e_t      req_type;
		logic [15:0] in_id;
		logic [7:0]  in_priority;
		logic [6:0]  position;
	} req_t;

	typedef struct packed {
		status_e_t   status;
		logic        out_valid;
		logic [15:0] out_id;
		logic [7:0]  out_priority;
		logic        found;
		logic [7:0]  count;
		logic [15:0] head_id;
		logic [7:0]  head_priority;
	} rsp_t;

	// per-cycle command broadcast to every cell of the row
	typedef struct packed {
		logic        insert;
		logic        remove;
		entry_t      ins;
		logic [6:0]  pos;
		logic [15:0] qry_id;
	} cell_ctl_t;

endpackage

/* hdl/spq_cell.sv */
`timescale 1ns / 1ps

module spq_cell #(
	parameter int CAPACITY = 128,
	parameter int IDX      = 0
) (
	input  logic                          clk,
	input  spq_pkg::cell_ctl_t            ctl,
	input  logic [$clog2(CAPACITY+1)-1:0] count,
	input  spq_pkg::entry_t               left_ent,
	input  logic                          left_ge,
	input  spq_pkg::entry_t               right_ent,
	output spq_pkg::entry_t               ent,
	output logic                          ge,
	output logic                          match
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

	spq_pkg::entry_t ent_q;
	logic            occ;
	logic            first;
	logic            at_or_after;

	// occupancy follows from the fill count; empty cells rank as greater than anything
	assign occ         = CNT_W'(IDX) < count;
	assign ge          = !occ || (ent_q.pri > ctl.ins.pri);
	assign first       = ge && !left_ge;
	assign at_or_after = CMP_W'(IDX) >= CMP_W'(ctl.pos);
	assign match       = occ && (ent_q.id == ctl.qry_id);
	assign ent         = ent_q;

	// take the new entry, shift right on insert, shift left on removal
	always_ff @(posedge clk) begin
		if (ctl.insert) begin
			if (first) begin
				ent_q <= ctl.ins;
			end else if (ge) begin
				ent_q <= left_ent;
			end
		end else if (ctl.remove && at_or_after) begin
			ent_q <= right_ent;
		end
	end

endmodule

/* hdl/spq_group.sv */
`timescale 1ns / 1ps

module spq_group (
	input  logic                          clk,
	input  spq_pkg::entry_t               ent [spq_pkg::GROUP],
	input  logic [spq_pkg::GROUP-1:0]     match,
	input  logic [spq_pkg::LOC_W-1:0]     sel,
	output spq_pkg::entry_t               picked_s1,
	output logic                          any_s1
);

	// register the selected entry and the match summary of this group
	always_ff @(posedge clk) begin
		picked_s1 <= ent[sel];
		any_s1    <= |match;
	end

endmodule

/* hdl/sorted_priority_queue_top.sv */
`timescale 1ns / 1ps

// Sorted priority queue held in a row of cells, one entry per cell, kept in
// ascending priority order (equal priorities stay in arrival order). A request
// is taken when start is high and busy is low; its result appears on result
// for exactly one cycle with done high, and must be captured then, as the block
// cannot be held off. On insert every cell decides its move from its own and its
// left neighbour's comparison; on remove-head every cell takes its right
// neighbour's entry. The result follows in the next cycle, when a new request may
// already be taken. Remove at position and membership query hold busy while the
// pick and the match summary pass a two-level tree over groups of 32 cells, with
// a register per group, before the row updates. After reset the queue is empty.
module sorted_priority_queue_top #(
	parameter int CAPACITY = 128
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  spq_pkg::req_t req,
	output logic          done,
	output spq_pkg::rsp_t result
);

	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CMP_W    = (CNT_W > 7) ? CNT_W : 7;
	localparam int GROUPS   = (CAPACITY + spq_pkg::GROUP - 1) / spq_pkg::GROUP;
	localparam int GRP_W    = (GROUPS > 1) ? $clog2(GROUPS) : 1;
	localparam int GROUPS_P = 1 << GRP_W;
	localparam int NPAD     = GROUPS_P * spq_pkg::GROUP;

	spq_pkg::state_t    state_q, state_d;
	spq_pkg::req_t      req_q;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	spq_pkg::rsp_t      rsp_q, rsp_d;
	logic               done_q, done_d;
	spq_pkg::cell_ctl_t ctl;
	logic               accept;
	logic               full;

	spq_pkg::entry_t    cell_ent [CAPACITY];
	logic               cell_ge  [CAPACITY];
	logic [CAPACITY-1:0] cell_match;
	spq_pkg::entry_t    pad_ent  [NPAD];
	logic [NPAD-1:0]    pad_match;
	spq_pkg::entry_t    grp_ent_s1 [GROUPS_P];
	logic [GROUPS_P-1:0] grp_any_s1;
	logic [GRP_W-1:0]   gidx;

	assign busy   = state_q != spq_pkg::S_IDLE;
	assign accept = start && !busy;
	assign full   = cnt_q == CNT_W'(CAPACITY);
	assign done   = done_q;
	assign result = rsp_q;
	assign gidx   = GRP_W'(req_q.position >> spq_pkg::LOC_W);

	// row of cells, each linked to both neighbours
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		spq_pkg::entry_t left_ent;
		spq_pkg::entry_t right_ent;
		logic            left_ge;
		if (i == 0) begin : g_first
			assign left_ent = '0;
			assign left_ge  = 1'b0;
		end else begin : g_mid
			assign left_ent = cell_ent[i-1];
			assign left_ge  = cell_ge[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_ent = '0;
		end else begin : g_inner
			assign right_ent = cell_ent[i+1];
		end
		spq_cell #(
			.CAPACITY(CAPACITY),
			.IDX     (i)
		) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.count    (cnt_q),
			.left_ent (left_ent),
			.left_ge  (left_ge),
			.right_ent(right_ent),
			.ent      (cell_ent[i]),
			.ge       (cell_ge[i]),
			.match    (cell_match[i])
		);
	end

	// pad the row up to whole groups
	for (genvar k = 0; k < NPAD; k++) begin : g_pad
		if (k < CAPACITY) begin : g_real
			assign pad_ent[k]   = cell_ent[k];
			assign pad_match[k] = cell_match[k];
		end else begin : g_none
			assign pad_ent[k]   = '0;
			assign pad_match[k] = 1'b0;
		end
	end

	// first level of the selection tree
	for (genvar g = 0; g < GROUPS_P; g++) begin : g_grp
		spq_pkg::entry_t grp_in [spq_pkg::GROUP];
		for (genvar m = 0; m < spq_pkg::GROUP; m++) begin : g_in
			assign grp_in[m] = pad_ent[g*spq_pkg::GROUP + m];
		end
		spq_group u_group (
			.clk      (clk),
			.ent      (grp_in),
			.match    (pad_match[g*spq_pkg::GROUP +: spq_pkg::GROUP]),
			.sel      (req_q.position[spq_pkg::LOC_W-1:0]),
			.picked_s1(grp_ent_s1[g]),
			.any_s1   (grp_any_s1[g])
		);
	end

	// decide the cell command and build the result
	always_comb begin
		spq_pkg::entry_t head_e;
		spq_pkg::entry_t out_e;
		head_e          = (cnt_q != '0) ? cell_ent[0] : '0;
		out_e           = '0;
		rsp_d           = '0;
		rsp_d.status    = spq_pkg::ST_OK;
		cnt_d           = cnt_q;
		done_d          = 1'b0;
		ctl.insert      = 1'b0;
		ctl.remove      = 1'b0;
		ctl.ins.id      = req.in_id;
		ctl.ins.pri     = req.in_priority;
		ctl.pos         = '0;
		ctl.qry_id      = req_q.in_id;
		if (accept) begin
			unique case (req.req_type)
				spq_pkg::REQ_INSERT: begin
					done_d = 1'b1;
					if (full) begin
						rsp_d.status = spq_pkg::ST_FULL;
					end else begin
						ctl.insert = 1'b1;
						cnt_d      = CNT_W'(cnt_q + 1'b1);
						head_e     = cell_ge[0] ? ctl.ins : cell_ent[0];
					end
				end
				spq_pkg::REQ_REMOVE_HEAD: begin
					done_d = 1'b1;
					if (cnt_q == '0) begin
						rsp_d.status = spq_pkg::ST_EMPTY;
					end else begin
						ctl.remove      = 1'b1;
						rsp_d.out_valid = 1'b1;
						out_e           = cell_ent[0];
						cnt_d           = CNT_W'(cnt_q - 1'b1);
						head_e          = (cnt_d != '0) ? cell_ent[1] : '0;
					end
				end
				default: begin
				end
			endcase
		end else if (state_q == spq_pkg::S_FINISH) begin
			done_d = 1'b1;
			unique case (req_q.req_type)
				spq_pkg::REQ_REMOVE_AT: begin
					if (cnt_q == '0) begin
						rsp_d.status = spq_pkg::ST_EMPTY;
					end else if (CMP_W'(req_q.position) >= CMP_W'(cnt_q)) begin
						rsp_d.status = spq_pkg::ST_RANGE;
					end else begin
						ctl.remove      = 1'b1;
						ctl.pos         = req_q.position;
						rsp_d.out_valid = 1'b1;
						out_e           = grp_ent_s1[gidx];
						cnt_d           = CNT_W'(cnt_q - 1'b1);
						if (cnt_d == '0) begin
							head_e = '0;
						end else if (req_q.position == '0) begin
							head_e = cell_ent[1];
						end
					end
				end
				default: begin
					rsp_d.found = |grp_any_s1;
				end
			endcase
		end
		rsp_d.out_id        = out_e.id;
		rsp_d.out_priority  = out_e.pri;
		rsp_d.count         = 8'(cnt_d);
		rsp_d.head_id       = head_e.id;
		rsp_d.head_priority = head_e.pri;
	end

	// sequence the multi-cycle requests
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			spq_pkg::S_IDLE: begin
				if (accept && (req.req_type == spq_pkg::REQ_REMOVE_AT ||
				               req.req_type == spq_pkg::REQ_QUERY)) begin
					state_d = spq_pkg::S_GATHER;
				end
			end
			spq_pkg::S_GATHER: begin
				state_d = spq_pkg::S_FINISH;
			end
			spq_pkg::S_FINISH: begin
				state_d = spq_pkg::S_IDLE;
			end
			default: begin
				state_d = spq_pkg::S_IDLE;
			end
		endcase
	end

	// hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spq_pkg::S_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			done_q  <= done_d;
		end
	end

	// hold the request and the result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		rsp_q <= rsp_d;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == spq_pkg::S_FINISH |=> done_q && !busy)
		else $error("multi-cycle request finished without a result");

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("fill count beyond capacity");

	assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req.req_type == spq_pkg::REQ_INSERT ||
		           req.req_type == spq_pkg::REQ_REMOVE_HEAD) |=> done_q)
		else $error("single-cycle request gave no result");

	assert property (@(posedge clk) disable iff (!arst_n)
		done_q && rsp_q.status == spq_pkg::ST_FULL |-> full)
		else $error("full status while queue has room");

	assert property (@(posedge clk) disable iff (!arst_n)
		done_q && rsp_q.out_valid |-> rsp_q.status == spq_pkg::ST_OK && !rsp_q.found)
		else $error("removed entry reported with error status or found flag");

endmodule
